[sv/hsvg_pkg.sv]
// Shared types, constants and arithmetic helpers for the HSV to RGB gamma block.
// Used by the front, queue, back and top level modules; depends on nothing.
package hsvg_pkg;

    localparam int HueFull = 5760;
    localparam int HueSector = 960;
    localparam int PctFull = 100;
    localparam int QFull = 96000;
    localparam int LevelPerPct20 = 51;
    localparam int FifoDepthDefault = 4;
    localparam int BackStages = 5;

    typedef enum logic [2:0] {
        SecRedToYellow,
        SecYellowToGreen,
        SecGreenToCyan,
        SecCyanToBlue,
        SecBlueToMagenta,
        SecMagentaToRed
    } sector_t;

    typedef struct packed {
        sector_t     sector;
        logic [9:0]  rem;
        logic [6:0]  sat;
        logic [12:0] p_num;
        logic [12:0] scale_num;
    } front_item_t;

    localparam logic [7:0] GammaRom [256] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
        8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
        8'd7, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
        8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13,
        8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
        8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20,
        8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25,
        8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
        8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36,
        8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
        8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd50,
        8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
        8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd66, 8'd67, 8'd68,
        8'd69, 8'd70, 8'd72, 8'd73, 8'd74, 8'd75, 8'd77, 8'd78,
        8'd79, 8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd87, 8'd89,
        8'd90, 8'd92, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99, 8'd101,
        8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
        8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
        8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
        8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
        8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
        8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
        8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
        8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
    };

    // Floor of num / 20 for num up to 5100, by a reciprocal multiply.
    function automatic logic [7:0] div_by_20(input logic [12:0] num);
        logic [21:0] prod;
        prod = 22'(num[12:2]) * 22'd1639;
        return prod[20:13];
    endfunction

    // Floor of w / 255 for w up to 65025.
    function automatic logic [7:0] div_by_255(input logic [15:0] w);
        logic [16:0] sum;
        sum = 17'(w) + 17'd1 + 17'(w[15:8]);
        return sum[15:8];
    endfunction

endpackage

[sv/hsvg_front.sv]
// Front part: accepts input beats, clamps and wraps them, splits hue into sector and remainder.
// Depends on hsvg_pkg.
module hsvg_front
    import hsvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [12:0] hue,
    input  logic [6:0]  saturation,
    input  logic [6:0]  brightness,
    input  logic        power_on,
    output logic        item_valid,
    input  logic        item_ready,
    output front_item_t item
);

    logic        valid_reg;
    logic        valid_next;
    front_item_t item_reg;
    front_item_t item_next;
    logic        advance;
    logic [12:0] hue_w;
    logic [6:0]  sat_c;
    logic [6:0]  bri_c;

    assign advance = !valid_reg || item_ready;
    assign in_ready = advance;
    assign valid_next = advance ? in_valid : valid_reg;

    always_comb
    begin
        hue_w = (hue >= 13'(HueFull)) ? hue - 13'(HueFull) : hue;
        sat_c = (saturation > 7'(PctFull)) ? 7'(PctFull) : saturation;
        bri_c = (brightness > 7'(PctFull)) ? 7'(PctFull) : brightness;
        item_next.sat = sat_c;
        item_next.p_num = 13'(LevelPerPct20) * 13'(7'(PctFull) - sat_c);
        item_next.scale_num = power_on ? 13'(LevelPerPct20) * 13'(bri_c) : 13'd0;
        if (hue_w < 13'(HueSector))
        begin
            item_next.sector = SecRedToYellow;
            item_next.rem = 10'(hue_w);
        end
        else if (hue_w < 13'(2 * HueSector))
        begin
            item_next.sector = SecYellowToGreen;
            item_next.rem = 10'(hue_w - 13'(HueSector));
        end
        else if (hue_w < 13'(3 * HueSector))
        begin
            item_next.sector = SecGreenToCyan;
            item_next.rem = 10'(hue_w - 13'(2 * HueSector));
        end
        else if (hue_w < 13'(4 * HueSector))
        begin
            item_next.sector = SecCyanToBlue;
            item_next.rem = 10'(hue_w - 13'(3 * HueSector));
        end
        else if (hue_w < 13'(5 * HueSector))
        begin
            item_next.sector = SecBlueToMagenta;
            item_next.rem = 10'(hue_w - 13'(4 * HueSector));
        end
        else
        begin
            item_next.sector = SecMagentaToRed;
            item_next.rem = 10'(hue_w - 13'(5 * HueSector));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

[sv/hsvg_queue.sv]
// Short queue of classified beats between the front and back parts.
// Depends on hsvg_pkg.
module hsvg_queue
    import hsvg_pkg::*;
#(
    parameter int Depth = FifoDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    output logic        wr_ready,
    input  front_item_t wr_item,
    output logic        rd_valid,
    input  logic        rd_ready,
    output front_item_t rd_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    front_item_t mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic push;
    logic pop;

    assign wr_ready = (count_reg != CntW'(Depth));
    assign rd_valid = (count_reg != '0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

endmodule

[sv/hsvg_back.sv]
// Back part: five-stage pipeline that forms the channel levels, scales them and applies gamma.
// Depends on hsvg_pkg.
module hsvg_back
    import hsvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  front_item_t item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic [BackStages-1:0] vld_reg;
    logic [BackStages-1:0] vld_next;
    logic en;

    // Stage 1 registers.
    sector_t     s1_sector_reg;
    logic [7:0]  s1_p_reg;
    logic [7:0]  s1_scale_reg;
    logic [16:0] s1_prod_q_reg;
    logic [16:0] s1_prod_t_reg;
    // Stage 2 registers.
    sector_t     s2_sector_reg;
    logic [7:0]  s2_p_reg;
    logic [7:0]  s2_scale_reg;
    logic [12:0] s2_zq_reg;
    logic [12:0] s2_zt_reg;
    logic [12:0] s2_zq_next;
    logic [12:0] s2_zt_next;
    // Stage 3 registers.
    logic [7:0]  s3_scale_reg;
    logic [7:0]  s3_r_reg;
    logic [7:0]  s3_g_reg;
    logic [7:0]  s3_b_reg;
    logic [7:0]  s3_r_next;
    logic [7:0]  s3_g_next;
    logic [7:0]  s3_b_next;
    logic [25:0] mq;
    logic [25:0] mt;
    logic [7:0]  q_lvl;
    logic [7:0]  t_lvl;
    // Stage 4 registers.
    logic [15:0] s4_r_reg;
    logic [15:0] s4_g_reg;
    logic [15:0] s4_b_reg;
    // Output registers.
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    assign en = !vld_reg[BackStages-1] || out_ready;
    assign item_ready = en;
    assign vld_next = en ? {vld_reg[BackStages-2:0], item_valid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_comb
    begin
        logic [16:0] xq;
        logic [16:0] xt;
        logic [20:0] yq;
        logic [20:0] yt;
        xq = 17'(QFull) - s1_prod_q_reg;
        xt = 17'(QFull) - s1_prod_t_reg;
        yq = 21'(xq) * 21'd17;
        yt = 21'(xt) * 21'd17;
        s2_zq_next = yq[20:8];
        s2_zt_next = yt[20:8];
    end

    assign mq = 26'(s2_zq_reg) * 26'd5243;
    assign mt = 26'(s2_zt_reg) * 26'd5243;
    assign q_lvl = mq[24:17];
    assign t_lvl = mt[24:17];

    always_comb
    begin
        case (s2_sector_reg)
            SecRedToYellow:
            begin
                s3_r_next = 8'd255;
                s3_g_next = t_lvl;
                s3_b_next = s2_p_reg;
            end
            SecYellowToGreen:
            begin
                s3_r_next = q_lvl;
                s3_g_next = 8'd255;
                s3_b_next = s2_p_reg;
            end
            SecGreenToCyan:
            begin
                s3_r_next = s2_p_reg;
                s3_g_next = 8'd255;
                s3_b_next = t_lvl;
            end
            SecCyanToBlue:
            begin
                s3_r_next = s2_p_reg;
                s3_g_next = q_lvl;
                s3_b_next = 8'd255;
            end
            SecBlueToMagenta:
            begin
                s3_r_next = t_lvl;
                s3_g_next = s2_p_reg;
                s3_b_next = 8'd255;
            end
            default:
            begin
                s3_r_next = 8'd255;
                s3_g_next = s2_p_reg;
                s3_b_next = q_lvl;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sector_reg <= item.sector;
            s1_p_reg <= div_by_20(item.p_num);
            s1_scale_reg <= div_by_20(item.scale_num);
            s1_prod_q_reg <= 17'(item.sat) * 17'(item.rem);
            s1_prod_t_reg <= 17'(item.sat) * 17'(10'(HueSector) - item.rem);

            s2_sector_reg <= s1_sector_reg;
            s2_p_reg <= s1_p_reg;
            s2_scale_reg <= s1_scale_reg;
            s2_zq_reg <= s2_zq_next;
            s2_zt_reg <= s2_zt_next;

            s3_scale_reg <= s2_scale_reg;
            s3_r_reg <= s3_r_next;
            s3_g_reg <= s3_g_next;
            s3_b_reg <= s3_b_next;

            s4_r_reg <= 16'(s3_r_reg) * 16'(s3_scale_reg);
            s4_g_reg <= 16'(s3_g_reg) * 16'(s3_scale_reg);
            s4_b_reg <= 16'(s3_b_reg) * 16'(s3_scale_reg);

            red_reg <= GammaRom[div_by_255(s4_r_reg)];
            green_reg <= GammaRom[div_by_255(s4_g_reg)];
            blue_reg <= GammaRom[div_by_255(s4_b_reg)];
        end
    end

    assign out_valid = vld_reg[BackStages-1];
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

endmodule

[sv/hsv_to_rgb_gamma.sv]
// Throughput: one beat per cycle while out_ready is high; the front register and
// the queue each advance on their own handshake and the five back stages on one
// shared enable, so the block holds up to FifoDepth + 6 beats.
// Reset: rst_n clears all valid flags and queue pointers; payload registers are not reset.
// Depends on hsvg_pkg, hsvg_front, hsvg_queue and hsvg_back.
module hsv_to_rgb_gamma
    import hsvg_pkg::*;
#(
    parameter int FifoDepth = FifoDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [12:0] hue,
    input  logic [6:0]  saturation,
    input  logic [6:0]  brightness,
    input  logic        power_on,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic        fr_valid;
    logic        fr_ready;
    front_item_t fr_item;
    logic        bk_valid;
    logic        bk_ready;
    front_item_t bk_item;

    hsvg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .power_on   (power_on),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    hsvg_queue #(
        .Depth (FifoDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_item  (bk_item)
    );

    hsvg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (bk_valid),
        .item_ready (bk_ready),
        .item       (bk_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

[sv/hsvg_checker.sv]
// Port-level checker for hsv_to_rgb_gamma, bound to the top level.
// Depends on hsvg_pkg for the pipeline depth.
module hsvg_checker
    import hsvg_pkg::*;
#(
    parameter int FifoDepth = FifoDepthDefault
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    localparam int Capacity = FifoDepth + BackStages + 1;
    localparam int OutW = $clog2(Capacity + 2);

    logic [OutW-1:0] pending_reg;
    logic in_beat;
    logic out_beat;

    assign in_beat = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + OutW'(in_beat) - OutW'(out_beat);
    end

    // A stalled output beat keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
        else $error("output beat changed while stalled");

    // No output beat appears without an input beat behind it.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("output beat without a pending input beat");

    // The block never holds more beats than its storage.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= OutW'(Capacity))
        else $error("more beats in flight than the pipeline holds");

    // Once the last pending beat leaves, no copy of it follows.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && pending_reg == OutW'(1) && !in_beat |=> !out_valid)
        else $error("output beat repeated");

endmodule

bind hsv_to_rgb_gamma hsvg_checker #(
    .FifoDepth (FifoDepth)
) u_hsvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
);
